>>> hdl/tvb_pkg.sv
// Shared types, sizes and constants for the touch vector bearing block.
// No dependencies; imported by every module of the block.
package tvb_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_STEPS    = 18;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PRE_SHIFT = 60 - COORD_BITS;
    localparam int XY_W      = 64;
    localparam int Z_W       = 33;
    localparam int ZC_W      = 31;
    localparam int STEP_W    = 5;
    localparam int PROD_W    = 62;
    localparam int ROUND_SH  = 54 - ANGLE_FRAC_BITS;
    localparam int A_W       = ANGLE_FRAC_BITS + 8;
    localparam int BEARING_W = 15;
    localparam int B_W       = (ANGLE_FRAC_BITS + 10 > BEARING_W) ?
                               ANGLE_FRAC_BITS + 10 : BEARING_W;

    localparam logic [ZC_W-1:0]   ZMAX         = 31'h6487ED50;
    localparam logic [29:0]       DEG_PER_RAD  = 30'd961263669;
    localparam logic [PROD_W-1:0] ROUND_HALF   = PROD_W'(1) << (ROUND_SH - 1);
    localparam logic [B_W-1:0]    UNITS_90     = B_W'(90)  << ANGLE_FRAC_BITS;
    localparam logic [B_W-1:0]    UNITS_180    = B_W'(180) << ANGLE_FRAC_BITS;
    localparam logic [B_W-1:0]    UNITS_270    = B_W'(270) << ANGLE_FRAC_BITS;
    localparam logic [B_W-1:0]    UNITS_360    = B_W'(360) << ANGLE_FRAC_BITS;
    localparam logic [B_W-1:0]    UNITS_450    = B_W'(450) << ANGLE_FRAC_BITS;

    // signs and zero flags of the difference vector
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic dx_zero;
        logic dy_zero;
    } tvb_side_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        tvb_side_t              side;
    } tvb_cordic_t;

    // atan(2^-i) in radians, Q2.30
    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd31:   v = 32'h00000000;
            default: v = 32'h40000000 >> i;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tvb_cordic_cell.sv
// One vectoring CORDIC step with its pipeline register.
// Depends on tvb_pkg.
module tvb_cordic_cell
    import tvb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  logic              valid_in,
    input  tvb_cordic_t       data_in,
    output logic              valid_out,
    output tvb_cordic_t       data_out
);

    logic        valid_reg;
    tvb_cordic_t data_reg;
    tvb_cordic_t data_next;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  dz;

    always_comb
    begin
        xs = data_in.x >>> step;
        ys = data_in.y >>> step;
        dz = $signed(Z_W'(atan_q30(step)));
        data_next      = data_in;
        // rotate toward the x axis, y sign picks the direction
        if (!data_in.y[XY_W-1])
        begin
            data_next.x = data_in.x + ys;
            data_next.y = data_in.y - xs;
            data_next.z = data_in.z + dz;
        end
        else
        begin
            data_next.x = data_in.x - ys;
            data_next.y = data_in.y + xs;
            data_next.z = data_in.z - dz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

>>> hdl/tvb_bearing_out.sv
// Angle scaling to 1/2^ANGLE_FRAC_BITS degree, quadrant mapping, the multiply
// register and the output register. Depends on tvb_pkg.
module tvb_bearing_out
    import tvb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  tvb_cordic_t          data_in,
    output logic                 valid_out,
    output logic [BEARING_W-1:0] bearing_out
);

    logic                 mul_valid_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    tvb_side_t            side_reg;
    logic [ZC_W-1:0]      zc;

    logic                 out_valid_reg;
    logic [BEARING_W-1:0] bearing_reg;
    logic [BEARING_W-1:0] bearing_next;

    logic [PROD_W-1:0]    rounded;
    logic [B_W-1:0]       a;
    logic [B_W-1:0]       rt;
    logic [B_W-1:0]       b;

    // clamp to [0, pi/2] then radians to degrees in Q.54
    always_comb
    begin
        if (data_in.z[Z_W-1])
            zc = '0;
        else if (data_in.z > $signed(Z_W'(ZMAX)))
            zc = ZMAX;
        else
            zc = data_in.z[ZC_W-1:0];
        prod_next = PROD_W'(zc) * PROD_W'(DEG_PER_RAD);
    end

    always_comb
    begin
        rounded = prod_reg + ROUND_HALF;
        a       = B_W'(rounded[ROUND_SH +: A_W]);
        if (!side_reg.dx_zero && !side_reg.dy_zero)
        begin
            if (!side_reg.dx_neg)
                rt = side_reg.dy_neg ? a : UNITS_360 - a;
            else
                rt = side_reg.dy_neg ? UNITS_180 - a : UNITS_180 + a;
        end
        else if (!side_reg.dx_zero)
            rt = side_reg.dx_neg ? UNITS_180 : '0;
        else
            rt = side_reg.dy_neg ? UNITS_90 : UNITS_270;   // equal points land here
        b = UNITS_450 - rt;
        if (b >= UNITS_360)
            b = b - UNITS_360;
        bearing_next = b[BEARING_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= valid_in;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_next;
            side_reg    <= data_in.side;
            bearing_reg <= bearing_next;
        end
    end

    assign valid_out   = out_valid_reg;
    assign bearing_out = bearing_reg;

endmodule

>>> hdl/touch_vector_bearing_angle_core.sv
// Top level of the touch vector bearing block: difference stage, CORDIC
// cell chain and output stage. Depends on tvb_pkg, tvb_cordic_cell, tvb_bearing_out.
//
// Usage:
//   Input channel pair_valid/pair_stall carries start_x, start_y, end_x, end_y
//   (signed pixels, y grows downward). A request is taken on a rising edge with
//   pair_valid high and pair_stall low.
//   Output channel bearing_valid/bearing_stall carries bearing, the clockwise
//   angle from up in 1/64 degree, 0..23039. Identical points give 180 degrees.
//   Path: a request passes the difference stage, one register per CORDIC
//   cell, the multiply stage and the output register before its result shows
//   on bearing_valid. Throughput: one request per cycle unless the pipeline
//   halts; every stage holds an independent request.
//   The whole pipeline moves together; it halts only while a result sits in
//   the output register and bearing_stall is high, and pair_stall follows
//   that condition. A stalled result holds steady.
//   Reset (rst_n low, asynchronous) clears all valid bits; in-flight requests
//   are dropped.
module touch_vector_bearing_angle_core
    import tvb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pair_valid,
    output logic                  pair_stall,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  bearing_valid,
    input  logic                  bearing_stall,
    output logic [BEARING_W-1:0]  bearing
);

    logic en;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;

    logic        s0_valid_reg;
    tvb_cordic_t s0_reg;
    tvb_cordic_t s0_next;

    logic        cell_valid [0:CORDIC_STEPS];
    tvb_cordic_t cell_data  [0:CORDIC_STEPS];

    assign en         = !(bearing_valid && bearing_stall);
    assign pair_stall = !en;

    always_comb
    begin
        dx = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
        dy = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
        ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        s0_next.x            = $signed(XY_W'(ax) << PRE_SHIFT);
        s0_next.y            = $signed(XY_W'(ay) << PRE_SHIFT);
        s0_next.z            = '0;
        s0_next.side.dx_neg  = dx[DIFF_W-1];
        s0_next.side.dy_neg  = dy[DIFF_W-1];
        s0_next.side.dx_zero = (dx == '0);
        s0_next.side.dy_zero = (dy == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= pair_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_reg <= s0_next;
    end

    assign cell_valid[0] = s0_valid_reg;
    assign cell_data[0]  = s0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        tvb_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(i)),
            .valid_in  (cell_valid[i]),
            .data_in   (cell_data[i]),
            .valid_out (cell_valid[i+1]),
            .data_out  (cell_data[i+1])
        );
    end

    tvb_bearing_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .valid_in    (cell_valid[CORDIC_STEPS]),
        .data_in     (cell_data[CORDIC_STEPS]),
        .valid_out   (bearing_valid),
        .bearing_out (bearing)
    );

endmodule

>>> hdl/tvb_checker.sv
// Port-level checks for the touch vector bearing block, bound to the top level.
// Depends on tvb_pkg and touch_vector_bearing_angle_core.
module tvb_checker
    import tvb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pair_stall,
    input logic                  bearing_valid,
    input logic                  bearing_stall,
    input logic [BEARING_W-1:0]  bearing
);

    // input side only backs up when a finished result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (bearing_valid && bearing_stall))
        else $error("pair_stall without a held result");

    // a held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (bearing_valid && bearing_stall) |=> (bearing_valid && $stable(bearing)))
        else $error("stalled result changed");

    // bearing stays below a full turn (checked when ANGLE_FRAC_BITS is 6 or less)
    assert property (@(posedge clk) disable iff (!rst_n)
        bearing_valid |-> ((ANGLE_FRAC_BITS > 6) ||
                           (B_W'(bearing) < UNITS_360)))
        else $error("bearing out of range");

    // nothing can leave the pipeline right after reset
    assert property (@(posedge clk)
        !rst_n |=> !bearing_valid)
        else $error("result valid right after reset");

endmodule

bind touch_vector_bearing_angle_core tvb_checker u_tvb_checker (.*);
